// ===== src/rqd_pkg.sv =====
// Shared types and constants of the ready queue dispatcher.
`default_nettype none
package rqd_pkg;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned AGE_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned POLICY_W = 2;
  localparam int unsigned QUANTUM_W = 7;

  // Pick rules.
  localparam logic [POLICY_W-1:0] POLICY_FCFS = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_SJF  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_RR   = 2'd2;

  localparam logic [POLICY_W-1:0]  POLICY_RESET  = POLICY_RR;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 7'd20;

  // Configuration register indexes (bit 2 of the byte address).
  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REQUEUED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd4;

  typedef struct packed {
    logic [ID_W-1:0]  job;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] remaining;
    logic [AGE_W-1:0] age;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic clear;
    logic cand_valid;
    logic sjf;
  } pick_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/rqd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rqd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/rqd_cfg.sv =====
// APB-style configuration registers: pick rule and round robin quantum.
`default_nettype none
module rqd_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [2:0]                      paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic      [rqd_pkg::POLICY_W-1:0]    policy,
  output logic      [rqd_pkg::QUANTUM_W-1:0]   quantum
);

  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy  <= rqd_pkg::POLICY_RESET;
      quantum <= rqd_pkg::QUANTUM_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        rqd_pkg::REG_POLICY:  policy  <= pwdata[rqd_pkg::POLICY_W-1:0];
        rqd_pkg::REG_QUANTUM: quantum <= pwdata[rqd_pkg::QUANTUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rqd_pkg::REG_POLICY:  prdata = {{(32-rqd_pkg::POLICY_W){1'b0}}, policy};
      rqd_pkg::REG_QUANTUM: prdata = {{(32-rqd_pkg::QUANTUM_W){1'b0}}, quantum};
      default:              prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/rqd_pick.sv =====
// Running best-slot tracker fed one slot per cycle during a dispatch scan.
`default_nettype none
module rqd_pick #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rqd_pkg::pick_ctrl_t           ctrl,
  input  wire rqd_pkg::slot_entry_t          cand,
  input  wire logic [$clog2(DEPTH)-1:0]      cand_idx,
  input  wire logic [rqd_pkg::AGE_W-1:0]     age_counter,
  output rqd_pkg::slot_entry_t               best,
  output logic      [$clog2(DEPTH)-1:0]      best_idx
);

  logic                        found;
  logic [rqd_pkg::AGE_W-1:0]   best_dist;
  logic [rqd_pkg::AGE_W-1:0]   cand_dist;
  logic                        older;
  logic                        take;

  // Larger wraparound distance from the age counter means an older job.
  assign cand_dist = age_counter - cand.age;
  assign older     = cand_dist > best_dist;

  always_comb begin
    if (!found) begin
      take = 1'b1;
    end else if (ctrl.sjf) begin
      take = (cand.length < best.length) || ((cand.length == best.length) && older);
    end else begin
      take = older;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (ctrl.cand_valid) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cand_valid && take) begin
      best      <= cand;
      best_idx  <= cand_idx;
      best_dist <= cand_dist;
    end
  end

endmodule
`default_nettype wire

// ===== src/ready_queue_dispatcher_top.sv =====
// Top level of the ready queue dispatcher.
`default_nettype none
// Ready queue dispatcher. Words enter on the s_ group: s_tuser is the operation
// (0 enqueue, 1 dispatch), s_tdata carries job id and job length. Each word gives
// one result word on the m_ group. Slot contents live in one RAM; a valid bit per
// slot sits in flip-flops. An enqueue walks the valid bits from slot 0 to the first
// free slot; a full queue answers without the walk. A dispatch reads every slot
// of the RAM once through its single read port and keeps the best candidate, then
// writes the picked slot back; an empty queue answers without the scan. One word
// is in work at a time, and a new word is taken while the previous result still
// waits on the m_ side.
module ready_queue_dispatcher_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Stream in.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [15:0] job_id, [31:16] job length
  input  wire logic [0:0]  s_tuser,   // [0] op
  // Stream out.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // [15:0] picked_id, [31:16] slice_run,
                                      // [47:32] remaining_left
  output logic      [2:0]  m_tuser,   // [2:0] status
  // Configuration.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW = $clog2(QUEUE_DEPTH + 1);

  rqd_pkg::state_t state, state_next;

  logic [rqd_pkg::POLICY_W-1:0]  policy;
  logic [rqd_pkg::QUANTUM_W-1:0] quantum;

  logic [QUEUE_DEPTH-1:0]        slot_valid;
  logic [rqd_pkg::AGE_W-1:0]     age_counter;
  logic [OW-1:0]                 occupancy;
  logic [IW-1:0]                 idx;
  logic                          idx_last;

  logic [rqd_pkg::ID_W-1:0]      job_id;
  logic [rqd_pkg::LEN_W-1:0]     job_len;

  logic                          pend;
  logic                          pend_valid;
  logic [IW-1:0]                 pend_idx;

  logic [rqd_pkg::STATUS_W-1:0]  res_status;
  logic [rqd_pkg::ID_W-1:0]      res_id;
  logic [rqd_pkg::LEN_W-1:0]     res_slice;
  logic [rqd_pkg::LEN_W-1:0]     res_left;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  rqd_pkg::slot_entry_t          ram_wdata;
  logic [IW-1:0]                 ram_raddr;
  rqd_pkg::slot_entry_t          ram_rdata;

  rqd_pkg::pick_ctrl_t           pick_ctrl;
  rqd_pkg::slot_entry_t          best;
  logic [IW-1:0]                 best_idx;

  logic                          accept;
  logic                          q_full;
  logic                          q_empty;
  logic                          rr;
  logic [rqd_pkg::LEN_W-1:0]     slice;
  logic [rqd_pkg::LEN_W-1:0]     left;
  logic                          out_load;

  assign pready   = 1'b1;
  assign accept   = s_tvalid & s_tready;
  assign q_full   = occupancy == OW'(QUEUE_DEPTH);
  assign q_empty  = occupancy == '0;
  assign idx_last = idx == IW'(QUEUE_DEPTH - 1);
  assign rr       = (policy != rqd_pkg::POLICY_FCFS) && (policy != rqd_pkg::POLICY_SJF);
  assign slice    = (rr && (best.remaining > {{(rqd_pkg::LEN_W-rqd_pkg::QUANTUM_W){1'b0}},
                    quantum})) ? {{(rqd_pkg::LEN_W-rqd_pkg::QUANTUM_W){1'b0}}, quantum}
                    : best.remaining;
  assign left     = best.remaining - slice;
  assign out_load = (state == rqd_pkg::S_DONE) && (!m_tvalid || m_tready);

  rqd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .policy  (policy),
    .quantum (quantum)
  );

  rqd_ram #(
    .WIDTH (rqd_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rqd_pick #(
    .DEPTH (QUEUE_DEPTH)
  ) u_pick (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (pick_ctrl),
    .cand        (ram_rdata),
    .cand_idx    (pend_idx),
    .age_counter (age_counter),
    .best        (best),
    .best_idx    (best_idx)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rqd_pkg::S_IDLE: begin
        if (accept) begin
          if (s_tuser[0] == 1'b0) begin
            state_next = q_full ? rqd_pkg::S_DONE : rqd_pkg::S_FREE;
          end else begin
            state_next = q_empty ? rqd_pkg::S_DONE : rqd_pkg::S_SCAN;
          end
        end
      end
      rqd_pkg::S_FREE: begin
        if (!slot_valid[idx]) begin
          state_next = rqd_pkg::S_DONE;
        end
      end
      rqd_pkg::S_SCAN: begin
        if (idx_last) begin
          state_next = rqd_pkg::S_DRAIN;
        end
      end
      rqd_pkg::S_DRAIN:  state_next = rqd_pkg::S_UPDATE;
      rqd_pkg::S_UPDATE: state_next = rqd_pkg::S_DONE;
      rqd_pkg::S_DONE: begin
        if (out_load) begin
          state_next = rqd_pkg::S_IDLE;
        end
      end
      default: state_next = rqd_pkg::S_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    s_tready             = 1'b0;
    ram_we               = 1'b0;
    ram_waddr            = idx;
    ram_wdata            = '0;
    ram_raddr            = idx;
    pick_ctrl.clear      = 1'b0;
    pick_ctrl.cand_valid = pend & pend_valid;
    pick_ctrl.sjf        = policy == rqd_pkg::POLICY_SJF;
    case (state)
      rqd_pkg::S_IDLE: begin
        s_tready        = 1'b1;
        pick_ctrl.clear = 1'b1;
      end
      rqd_pkg::S_FREE: begin
        ram_we              = !slot_valid[idx];
        ram_wdata.job       = job_id;
        ram_wdata.length    = job_len;
        ram_wdata.remaining = job_len;
        ram_wdata.age       = age_counter;
      end
      rqd_pkg::S_UPDATE: begin
        ram_we              = 1'b1;
        ram_waddr           = best_idx;
        ram_wdata.job       = best.job;
        ram_wdata.length    = best.length;
        ram_wdata.remaining = left;
        ram_wdata.age       = (left == '0) ? best.age : age_counter;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rqd_pkg::S_IDLE;
      slot_valid  <= '0;
      age_counter <= '0;
      occupancy   <= '0;
      pend        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      pend <= state == rqd_pkg::S_SCAN;
      case (state)
        rqd_pkg::S_FREE: begin
          if (!slot_valid[idx]) begin
            slot_valid[idx] <= 1'b1;
            age_counter     <= age_counter + 1'b1;
            occupancy       <= occupancy + 1'b1;
          end
        end
        rqd_pkg::S_UPDATE: begin
          if (left == '0) begin
            slot_valid[best_idx] <= 1'b0;
            occupancy            <= occupancy - 1'b1;
          end else begin
            age_counter <= age_counter + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      rqd_pkg::S_IDLE: begin
        idx <= '0;
        if (accept) begin
          job_id     <= s_tdata[15:0];
          job_len    <= s_tdata[31:16];
          res_id     <= '0;
          res_slice  <= '0;
          res_left   <= '0;
          res_status <= (s_tuser[0] == 1'b0) ? rqd_pkg::ST_FULL : rqd_pkg::ST_EMPTY;
        end
      end
      rqd_pkg::S_FREE: begin
        if (!slot_valid[idx]) begin
          res_status <= rqd_pkg::ST_ENQUEUED;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      rqd_pkg::S_SCAN: begin
        pend_idx   <= idx;
        pend_valid <= slot_valid[idx];
        if (!idx_last) begin
          idx <= idx + 1'b1;
        end
      end
      rqd_pkg::S_UPDATE: begin
        res_status <= (left == '0) ? rqd_pkg::ST_FINISHED : rqd_pkg::ST_REQUEUED;
        res_id     <= best.job;
        res_slice  <= slice;
        res_left   <= left;
      end
      default: ;
    endcase
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {res_left, res_slice, res_id};
    end
  end

endmodule
`default_nettype wire

// ===== test/ready_queue_dispatcher_top_test.sv =====
`timescale 1ns / 100ps
// Randomized stream testbench for the ready queue dispatcher with a self-checking queue mirror.
module ready_queue_dispatcher_top_test;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = QUEUE_DEPTH + 8;
  // The unused policy code behaves as round robin.
  localparam logic [rqd_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;

  typedef enum logic {
    OP_ENQUEUE  = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef struct packed {
    logic [rqd_pkg::STATUS_W-1:0] status;
    logic [rqd_pkg::ID_W-1:0]     picked;
    logic [rqd_pkg::LEN_W-1:0]    slice;
    logic [rqd_pkg::LEN_W-1:0]    left;
  } dispatch_result_t;

  class queue_mirror;
    logic [rqd_pkg::POLICY_W-1:0]  policy;
    logic [rqd_pkg::QUANTUM_W-1:0] quantum;
    bit                            slot_used [QUEUE_DEPTH];
    logic [rqd_pkg::ID_W-1:0]      slot_id   [QUEUE_DEPTH];
    logic [rqd_pkg::LEN_W-1:0]     slot_len  [QUEUE_DEPTH];
    logic [rqd_pkg::LEN_W-1:0]     slot_rem  [QUEUE_DEPTH];
    logic [rqd_pkg::AGE_W-1:0]     slot_age  [QUEUE_DEPTH];
    logic [rqd_pkg::AGE_W-1:0]     age_now;
    int unsigned                   fill;
    int unsigned                   mismatches;
    dispatch_result_t              pending_results [$];

    function new();
      policy     = rqd_pkg::POLICY_RESET;
      quantum    = rqd_pkg::QUANTUM_RESET;
      age_now    = '0;
      fill       = 0;
      mismatches = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
      if (idx == rqd_pkg::REG_POLICY) begin
        policy = value[rqd_pkg::POLICY_W-1:0];
      end else begin
        quantum = value[rqd_pkg::QUANTUM_W-1:0];
      end
    endfunction

    function logic [rqd_pkg::AGE_W-1:0] age_gap(int i);
      return age_now - slot_age[i];
    endfunction

    // Oldest valid slot, or under shortest job first the smallest total length
    // with ties going to the older job.
    function int pick_slot(bit shortest);
      int  best;
      bit  found;
      best  = 0;
      found = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (slot_used[i]) begin
          if (!found) begin
            best  = i;
            found = 1'b1;
          end else if (shortest) begin
            if (slot_len[i] < slot_len[best] ||
                (slot_len[i] == slot_len[best] && age_gap(i) > age_gap(best)))
              best = i;
          end else if (age_gap(i) > age_gap(best)) begin
            best = i;
          end
        end
      end
      return best;
    endfunction

    function void note_word(op_t op, logic [rqd_pkg::ID_W-1:0] id,
                            logic [rqd_pkg::LEN_W-1:0] len);
      dispatch_result_t          r;
      int                        slot;
      logic [rqd_pkg::LEN_W-1:0] rem;
      r    = '0;
      slot = -1;
      if (op == OP_ENQUEUE) begin
        r.status = rqd_pkg::ST_FULL;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
          if (!slot_used[i]) slot = i;
        if (fill < QUEUE_DEPTH && slot >= 0) begin
          slot_used[slot] = 1'b1;
          slot_id[slot]   = id;
          slot_len[slot]  = len;
          slot_rem[slot]  = len;
          slot_age[slot]  = age_now;
          age_now++;
          fill++;
          r.status = rqd_pkg::ST_ENQUEUED;
        end
      end else if (fill == 0) begin
        r.status = rqd_pkg::ST_EMPTY;
      end else begin
        slot    = pick_slot(policy == rqd_pkg::POLICY_SJF);
        rem     = slot_rem[slot];
        r.slice = rem;
        if (policy != rqd_pkg::POLICY_FCFS && policy != rqd_pkg::POLICY_SJF &&
            rem > {9'd0, quantum})
          r.slice = {9'd0, quantum};
        r.left         = rem - r.slice;
        r.picked       = slot_id[slot];
        slot_rem[slot] = r.left;
        if (r.left == '0) begin
          slot_used[slot] = 1'b0;
          fill--;
          r.status = rqd_pkg::ST_FINISHED;
        end else begin
          slot_age[slot] = age_now;
          age_now++;
          r.status = rqd_pkg::ST_REQUEUED;
        end
      end
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_word(logic [rqd_pkg::STATUS_W-1:0] status, logic [rqd_pkg::ID_W-1:0] picked,
                    logic [rqd_pkg::LEN_W-1:0] slice, logic [rqd_pkg::LEN_W-1:0] left);
      dispatch_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result word arrived with no result expected");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (picked !== want.picked)
          report_mismatch($sformatf("picked_id %0h, expected %0h", picked, want.picked));
        if (slice !== want.slice)
          report_mismatch($sformatf("slice_run %0d, expected %0d", slice, want.slice));
        if (left !== want.left)
          report_mismatch($sformatf("remaining_left %0d, expected %0d", left, want.left));
      end
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [15:0] job_id, [31:16] job length
  logic [0:0]  s_tuser;   // [0] op
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [15:0] picked_id, [31:16] slice_run, [47:32] remaining_left
  logic [2:0]  m_tuser;   // [2:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bit          steady = 1'b0;
  bit          long_stall_req = 1'b0;
  queue_mirror mirror = new();

  ready_queue_dispatcher_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      n = steady ? 0 : gap_len();
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      mirror.check_word(m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32]);
  end

  task automatic send_word(input op_t op, input logic [rqd_pkg::ID_W-1:0] id,
                           input logic [rqd_pkg::LEN_W-1:0] len);
    int n;
    n = steady ? 0 : gap_len();
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tuser  = 1'($urandom);
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {len, id};
    do @(posedge clk); while (!s_tready);
    mirror.note_word(op, id, len);
  endtask

  task automatic send_random_word(input int enq_pct, input bit narrow);
    logic [rqd_pkg::LEN_W-1:0] len;
    int                        r;
    r = $urandom_range(0, 99);
    if (r < 5) len = '0;
    else if (r < 12) len = 16'($urandom);
    else if (r < 15) len = '1;
    else if (narrow) len = 16'($urandom_range(1, 6));
    else len = 16'($urandom_range(1, 300));
    send_word(($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DISPATCH,
              16'($urandom), len);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    mirror.set_reg(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_drained();
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_word(OP_DISPATCH, 16'h1234, 16'h4321);
    send_word(OP_ENQUEUE, 16'h0000, 16'h0000);
    send_word(OP_ENQUEUE, 16'hFFFF, 16'hFFFF);
    send_word(OP_ENQUEUE, 16'h0001, 16'h0001);
    send_word(OP_ENQUEUE, 16'h5A5A, 16'd20);
    send_word(OP_ENQUEUE, 16'hA5A5, 16'd21);
    for (int i = 0; i < QUEUE_DEPTH - 5; i++)
      send_word(OP_ENQUEUE, 16'(100 + i), 16'(3 * i + 2));
    // The queue is full now, so this job is dropped.
    send_word(OP_ENQUEUE, 16'hBEEF, 16'd7);
    repeat (6) send_word(OP_DISPATCH, 16'($urandom), 16'($urandom));
  endtask

  task automatic run_phase(input logic [rqd_pkg::POLICY_W-1:0] pol,
                           input logic [rqd_pkg::QUANTUM_W-1:0] q,
                           input int count, input int enq_pct, input bit narrow,
                           input bit calm, input bit flood);
    @(negedge clk);
    s_tvalid = 1'b0;
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    write_reg(rqd_pkg::REG_POLICY, {30'd0, pol});
    write_reg(rqd_pkg::REG_QUANTUM, {25'd0, q});
    steady = calm;
    if (flood) long_stall_req = 1'b1;
    for (int k = 0; k < count; k++) send_random_word(enq_pct, narrow);
    steady = 1'b0;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_phase(rqd_pkg::POLICY_FCFS, 7'd20,  60, 55, 1'b0, 1'b0, 1'b0);
    run_phase(rqd_pkg::POLICY_SJF,  7'd10,  70, 55, 1'b1, 1'b0, 1'b0);
    run_phase(rqd_pkg::POLICY_RR,   7'd10,  60, 50, 1'b0, 1'b0, 1'b0);
    run_phase(rqd_pkg::POLICY_RR,   7'd100, 50, 50, 1'b0, 1'b0, 1'b0);
    run_phase(POLICY_SPARE,         7'd37,  40, 50, 1'b1, 1'b0, 1'b0);
    run_phase(rqd_pkg::POLICY_RR,   7'd0,   30, 50, 1'b0, 1'b0, 1'b0);
    run_phase(rqd_pkg::POLICY_RR,   7'd127, 40, 45, 1'b0, 1'b0, 1'b0);
    // Results are held back for a long stretch while words keep coming.
    run_phase(rqd_pkg::POLICY_SJF,  7'd100, 50, 50, 1'b0, 1'b1, 1'b1);
    run_phase(rqd_pkg::POLICY_FCFS, 7'd64,  40, 45, 1'b1, 1'b1, 1'b0);
    run_phase(rqd_pkg::POLICY_RR,   7'd20,  40, 40, 1'b0, 1'b0, 1'b0);

    @(negedge clk);
    s_tvalid = 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rqd_pkg.sv
src/rqd_ram.sv
src/rqd_cfg.sv
src/rqd_pick.sv
src/ready_queue_dispatcher_top.sv
test/ready_queue_dispatcher_top_test.sv
